[rtl/hetq_pkg.sv]
package hetq_pkg;

  localparam int ANG_W = 35;        // half angle, units of 2^-33 turn
  localparam int CS_W  = 34;        // CORDIC x/y, Q30 with headroom
  localparam int MAX_STAGES = 32;
  localparam int CORDIC_STAGES_DEF = 30;

  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'sd1 << 31);
  localparam logic signed [ANG_W-1:0] HALF    = ANG_W'(64'sd1 << 32);
  localparam logic signed [CS_W-1:0]  Q30_ONE = CS_W'(64'sd1 << 30);

  localparam logic [31:0] ATAN_TURN32 [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [ANG_W-1:0] ang;
    logic                    flip;
  } fold_t;

  // Elaboration-time CORDIC start value: floor(2^60 / floor(sqrt(P))).
  function automatic logic [63:0] cordic_gain(input int n);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] q;
    logic [63:0] trial;
    p = 64'd1 << 60;
    for (int i = 0; i < n; i++) p = p + (p >> (2 * i));
    r = 64'd0;
    bit_v = 64'd1 << 62;
    while (bit_v > p) bit_v = bit_v >> 2;
    while (bit_v != 64'd0) begin
      if (p >= r + bit_v) begin
        p = p - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (r == 64'd0) return 64'd1 << 30;
    q = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      trial = q | (64'd1 << i);
      if (trial * r <= (64'd1 << 60)) q = trial;
    end
    return q;
  endfunction

  function automatic fold_t fold_angle(input logic signed [ANG_W-1:0] a);
    fold_t f;
    f.ang  = a;
    f.flip = 1'b0;
    if (a > QUARTER) begin
      f.ang  = a - HALF;
      f.flip = 1'b1;
    end else if (a < -QUARTER) begin
      f.ang  = a + HALF;
      f.flip = 1'b1;
    end
    return f;
  endfunction

  function automatic logic signed [31:0] sat30(input logic signed [CS_W-1:0] v);
    if (v > Q30_ONE) return 32'(Q30_ONE);
    if (v < -Q30_ONE) return 32'(-Q30_ONE);
    return v[31:0];
  endfunction

  // (a*b + 2^29) >>> 30, round half up
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
    return p[61:30];
  endfunction

endpackage

[rtl/hetq_cordic.sv]
module hetq_cordic #(
  parameter int NS = hetq_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hetq_pkg::ANG_W-1:0] angle,
  input  logic                              flip,
  output logic signed [31:0]                cos_q,
  output logic signed [31:0]                sin_q
);

  localparam logic signed [hetq_pkg::CS_W-1:0] K0 =
    hetq_pkg::CS_W'(hetq_pkg::cordic_gain(NS));

  logic signed [hetq_pkg::CS_W-1:0]  xs [NS+1];
  logic signed [hetq_pkg::CS_W-1:0]  ys [NS+1];
  logic signed [hetq_pkg::ANG_W-1:0] zs [NS+1];
  logic                              fs [NS+1];

  assign xs[0] = K0;
  assign ys[0] = '0;
  assign zs[0] = angle;
  assign fs[0] = flip;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [hetq_pkg::ANG_W-1:0] DA =
      $signed({2'b00, hetq_pkg::ATAN_TURN32[i], 1'b0});
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - DA;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + DA;
        end
        fs[i+1] <= fs[i];
      end
    end
  end

  // saturate, undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= fs[NS] ? -hetq_pkg::sat30(xs[NS]) : hetq_pkg::sat30(xs[NS]);
      sin_q <= fs[NS] ? -hetq_pkg::sat30(ys[NS]) : hetq_pkg::sat30(ys[NS]);
    end
  end

endmodule

[rtl/hetq_mult.sv]
module hetq_mult (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] cr,
  input  logic signed [31:0] sr,
  input  logic signed [31:0] cp,
  input  logic signed [31:0] sp,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] sy,
  output logic signed [31:0] qw,
  output logic signed [31:0] qx,
  output logic signed [31:0] qy,
  output logic signed [31:0] qz
);

  logic signed [31:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [31:0] cy1, sy1;
  logic signed [31:0] t1, t2, t3, t4, t5, t6, t7, t8;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cc <= hetq_pkg::qmul(cp, cr);
      p_ss <= hetq_pkg::qmul(sp, sr);
      p_sc <= hetq_pkg::qmul(sp, cr);
      p_cs <= hetq_pkg::qmul(cp, sr);
      cy1  <= cy;
      sy1  <= sy;
      t1 <= hetq_pkg::qmul(p_cc, cy1);
      t2 <= hetq_pkg::qmul(p_ss, sy1);
      t3 <= hetq_pkg::qmul(p_sc, cy1);
      t4 <= hetq_pkg::qmul(p_cs, sy1);
      t5 <= hetq_pkg::qmul(p_cs, cy1);
      t6 <= hetq_pkg::qmul(p_sc, sy1);
      t7 <= hetq_pkg::qmul(p_cc, sy1);
      t8 <= hetq_pkg::qmul(p_ss, cy1);
      qw <= hetq_pkg::sat30(hetq_pkg::CS_W'(t1) - hetq_pkg::CS_W'(t2));
      qx <= hetq_pkg::sat30(hetq_pkg::CS_W'(t3) - hetq_pkg::CS_W'(t4));
      qy <= hetq_pkg::sat30(hetq_pkg::CS_W'(t5) + hetq_pkg::CS_W'(t6));
      qz <= hetq_pkg::sat30(hetq_pkg::CS_W'(t7) + hetq_pkg::CS_W'(t8));
    end
  end

endmodule

[rtl/heading_euler_to_quaternion.sv]
// heading_euler_to_quaternion
// Slave stream s_*: one attitude word per handshake (roll, pitch, azimuth,
// binary angles, 2^32 = one turn). Master stream m_*: one quaternion word
// (w, x, y, z, signed Q1.30) for every input word, in order.
// cfg_wen/cfg_wdata write yaw_mirror; write it only while the pipe is empty.
// Pipeline: angle prep, one register per CORDIC iteration (NS = CORDIC_STAGES
// capped at 32), saturate, two product ranks, sum/saturate into the output.
// Throughput: one word per clock when not stalled; the three half-angle CORDICs run side by
// side, one iteration per stage.
// Stall: when m_tready is low with a word waiting, the whole pipe freezes
// and s_tready drops; nothing is lost or repeated, bubbles stay in place.
// Reset (rst, synchronous): clears every valid bit and yaw_mirror; data
// registers are not reset.
module heading_euler_to_quaternion #(
  parameter int CORDIC_STAGES = hetq_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // roll_angle, pitch_angle, azimuth_angle
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // quat_w, quat_x, quat_y, quat_z
  input  logic         cfg_wen,
  input  logic         cfg_wdata  // yaw_mirror
);

  localparam int NS  = (CORDIC_STAGES > hetq_pkg::MAX_STAGES) ?
                       hetq_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = NS + 5;
  localparam int AW  = hetq_pkg::ANG_W;

  logic yaw_mirror;
  logic en;
  logic [LAT-1:0] vpipe;

  logic signed [AW-1:0] roll_ext, pitch_neg, yaw_a, yaw_b, yaw_c;
  hetq_pkg::fold_t f_roll, f_pitch, f_yaw;
  hetq_pkg::fold_t r_roll, r_pitch, r_yaw;

  logic signed [31:0] cr, sr, cp, sp, cy, sy;
  logic signed [31:0] qw, qx, qy, qz;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vpipe[LAT-1];
  assign m_tdata  = {qz, qy, qx, qw};

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_mirror <= 1'b0;
    end else if (cfg_wen) begin
      yaw_mirror <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], s_tvalid};
    end
  end

  // angle prep: negate pitch, azimuth -> east-referenced yaw on 35 bits, optional yaw mirror, half-turn fold
  always_comb begin
    roll_ext  = AW'($signed(s_tdata[31:0]));
    pitch_neg = -AW'($signed(s_tdata[63:32]));
    yaw_a     = (AW'(64'sd1 << 30)) - $signed({3'b000, s_tdata[95:64]});
    yaw_b     = (yaw_a < 0) ? yaw_a + hetq_pkg::HALF : yaw_a;
    yaw_c     = yaw_mirror ? hetq_pkg::HALF - yaw_b : yaw_b;
    f_roll    = hetq_pkg::fold_angle(roll_ext);
    f_pitch   = hetq_pkg::fold_angle(pitch_neg);
    f_yaw     = hetq_pkg::fold_angle(yaw_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_roll  <= f_roll;
      r_pitch <= f_pitch;
      r_yaw   <= f_yaw;
    end
  end

  hetq_cordic #(.NS(NS)) u_roll (
    .clk(clk), .en(en), .angle(r_roll.ang), .flip(r_roll.flip),
    .cos_q(cr), .sin_q(sr)
  );

  hetq_cordic #(.NS(NS)) u_pitch (
    .clk(clk), .en(en), .angle(r_pitch.ang), .flip(r_pitch.flip),
    .cos_q(cp), .sin_q(sp)
  );

  hetq_cordic #(.NS(NS)) u_yaw (
    .clk(clk), .en(en), .angle(r_yaw.ang), .flip(r_yaw.flip),
    .cos_q(cy), .sin_q(sy)
  );

  hetq_mult u_mult (
    .clk(clk), .en(en),
    .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz)
  );

`ifndef ASSERT_OFF
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vpipe[0])
    else $error("accepted word did not enter the pipe");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vpipe))
    else $error("valid bits moved during a stall");

  a_range_w: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824 &&
                  $signed(m_tdata[31:0]) >= -32'sd1073741824))
    else $error("quat_w out of Q1.30 range");

  a_range_z: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[127:96]) <= 32'sd1073741824 &&
                  $signed(m_tdata[127:96]) >= -32'sd1073741824))
    else $error("quat_z out of Q1.30 range");
`endif

endmodule
